/* hw/rtl/fres_pkg.sv */
package fres_pkg;

    localparam logic [31:0] SIGN_MASK  = 32'h8000_0000;
    localparam logic [22:0] QUIET_BIT  = 23'h40_0000;
    localparam logic [30:0] INF_BITS   = 31'h7F80_0000;
    localparam logic [30:0] MAX_FINITE = 31'h7F7F_FFFF;
    localparam logic [22:0] SUBN_LIMIT = 23'h20_0000;
    localparam logic [9:0]  EXP_BIAS_SUM = 10'd253;

    function automatic logic [22:0] rom_base(input logic [4:0] idx);
        logic [22:0] r;
        case (idx)
            5'd0:  r = 23'h7ff800;
            5'd1:  r = 23'h783800;
            5'd2:  r = 23'h70ea00;
            5'd3:  r = 23'h6a0800;
            5'd4:  r = 23'h638800;
            5'd5:  r = 23'h5d6200;
            5'd6:  r = 23'h579000;
            5'd7:  r = 23'h520800;
            5'd8:  r = 23'h4cc800;
            5'd9:  r = 23'h47ca00;
            5'd10: r = 23'h430800;
            5'd11: r = 23'h3e8000;
            5'd12: r = 23'h3a2c00;
            5'd13: r = 23'h360800;
            5'd14: r = 23'h321400;
            5'd15: r = 23'h2e4a00;
            5'd16: r = 23'h2aa800;
            5'd17: r = 23'h272c00;
            5'd18: r = 23'h23d600;
            5'd19: r = 23'h209e00;
            5'd20: r = 23'h1d8800;
            5'd21: r = 23'h1a9000;
            5'd22: r = 23'h17ae00;
            5'd23: r = 23'h14f800;
            5'd24: r = 23'h124400;
            5'd25: r = 23'h0fbe00;
            5'd26: r = 23'h0d3800;
            5'd27: r = 23'h0ade00;
            5'd28: r = 23'h088400;
            5'd29: r = 23'h065000;
            5'd30: r = 23'h041c00;
            default: r = 23'h020c00;
        endcase
        return r;
    endfunction

    function automatic logic [9:0] rom_dec(input logic [4:0] idx);
        logic [9:0] r;
        case (idx)
            5'd0:  r = 10'h3e1;
            5'd1:  r = 10'h3a7;
            5'd2:  r = 10'h371;
            5'd3:  r = 10'h340;
            5'd4:  r = 10'h313;
            5'd5:  r = 10'h2ea;
            5'd6:  r = 10'h2c4;
            5'd7:  r = 10'h2a0;
            5'd8:  r = 10'h27f;
            5'd9:  r = 10'h261;
            5'd10: r = 10'h245;
            5'd11: r = 10'h22a;
            5'd12: r = 10'h212;
            5'd13: r = 10'h1fb;
            5'd14: r = 10'h1e5;
            5'd15: r = 10'h1d1;
            5'd16: r = 10'h1be;
            5'd17: r = 10'h1ac;
            5'd18: r = 10'h19b;
            5'd19: r = 10'h18b;
            5'd20: r = 10'h17c;
            5'd21: r = 10'h16e;
            5'd22: r = 10'h15b;
            5'd23: r = 10'h15b;
            5'd24: r = 10'h143;
            5'd25: r = 10'h143;
            5'd26: r = 10'h12d;
            5'd27: r = 10'h12d;
            5'd28: r = 10'h11a;
            5'd29: r = 10'h11a;
            5'd30: r = 10'h108;
            default: r = 10'h106;
        endcase
        return r;
    endfunction

endpackage

/* hw/rtl/fp32_reciprocal_estimate_core.sv */
// channel | dir | tdata fields (low bit up)
// s_axis  | in  | value_bits[31:0]
// m_axis  | out | estimate_bits[31:0]
// one word per cycle while the output is not stalled; input register, then one
// pass of table, multiply and subtract into the output register
// rst_n clears only the two valid flags
// a stalled output holds; the input stage takes a word when it is empty or can
// move forward in the same cycle
module fp32_reciprocal_estimate_core
    import fres_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // value_bits
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // estimate_bits
);

    logic        in_valid_reg;
    logic [31:0] in_data_reg;
    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic        out_ready;
    logic        in_ready;

    logic        sgn;
    logic [7:0]  ex_in;
    logic [22:0] frac_in;
    logic [22:0] frac;
    logic [9:0]  ex;          // two's complement, holds -1..255
    logic [4:0]  idx;
    logic [19:0] prod;
    logic [22:0] rfrac;
    logic [9:0]  rexp;
    logic [31:0] result_next;

    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign in_ready      = !in_valid_reg || out_ready;
    assign s_axis_tready = in_ready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        sgn     = in_data_reg[31];
        ex_in   = in_data_reg[30:23];
        frac_in = in_data_reg[22:0];
        frac    = frac_in;
        ex      = {2'b00, ex_in};
        if (ex_in == 8'd0)
        begin
            if (frac_in < QUIET_BIT)
            begin
                frac = {frac_in[20:0], 2'b00};
                ex   = 10'h3FF;
            end
            else
            begin
                frac = {frac_in[21:0], 1'b0};
            end
        end
        idx   = frac[22:18];
        prod  = rom_dec(idx) * frac[17:8];
        // prod + 1 fits 21 bits; halve then subtract
        rfrac = rom_base(idx) - 23'({1'b0, prod} + 21'd1 >> 1);
        rexp  = EXP_BIAS_SUM - ex;

        if (ex_in == 8'hFF)
        begin
            if (frac_in != 23'd0)
                result_next = in_data_reg | {9'd0, QUIET_BIT};
            else
                result_next = in_data_reg & SIGN_MASK;
        end
        else if (ex_in == 8'd0 && frac_in == 23'd0)
            result_next = {sgn, INF_BITS};
        else if (ex_in == 8'd0 && frac_in < SUBN_LIMIT)
            result_next = {sgn, MAX_FINITE};
        else if (ex_in >= 8'd253)
            result_next = {sgn, 31'd0};
        else
            result_next = {sgn, rexp[7:0], rfrac};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= s_axis_tvalid;
            if (out_ready)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && s_axis_tvalid)
            in_data_reg <= s_axis_tdata;
        if (out_ready && in_valid_reg)
            out_data_reg <= result_next;
    end

`ifndef NO_ASSERTIONS
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");
    a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_ready |=> in_valid_reg && $stable(in_data_reg))
        else $error("input stage dropped a word");
    a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_ready |=> m_axis_tvalid)
        else $error("word did not reach output");
`endif

endmodule
